// ===== src/wsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types and constants shared by the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  // Parser phase, one-hot encoded
  typedef enum logic [5:0] {
    PH_B0   = 6'b000001,  // first header byte: FIN, opcode
    PH_B1   = 6'b000010,  // second header byte: MASK, 7-bit length
    PH_EXT  = 6'b000100,  // extended length bytes
    PH_KEY  = 6'b001000,  // masking key bytes
    PH_PAY  = 6'b010000,  // payload bytes
    PH_HALT = 6'b100000   // stopped after a length error
  } phase_t;

  // Result event codes
  typedef enum logic [2:0] {
    EV_DATA   = 3'd0,
    EV_CLOSE  = 3'd1,
    EV_PING   = 3'd2,
    EV_PONG   = 3'd3,
    EV_BADLEN = 3'd4,
    EV_OVER   = 3'd5
  } event_t;

  // Frame opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // 7-bit length codes that select an extension
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Length accumulator width (64-bit extension plus its checks)
  localparam int unsigned AccWidth = 64;

  // Smallest legal 16-bit extended length; largest value too small for 64-bit
  localparam logic [AccWidth-1:0] MinExt16 = 64'd126;
  localparam logic [AccWidth-1:0] MaxShort = 64'h0000_0000_0000_FFFF;

  // Extension byte counts
  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;
  localparam logic [3:0] KeyBytes   = 4'd4;

  // Reset value of the frame limit: 50 MiB
  localparam logic [31:0] MaxFrameReset = 32'(50 * 1024 * 1024);

endpackage

// ===== src/websocket_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Results are registered: each appears in the cycle after its byte is taken.
// One byte per cycle while the output register is free or out_ready is high;
// header and unmask updates: combinational, parser state to output register.
// Reset (synchronous, rst_n low): parser waits for a first header byte, no
// message open, frame limit set to 52428800 bytes.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit #(
  parameter int unsigned LENGTH_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_max_frame_bytes,
  // byte stream in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  // results out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [3:0]  out_msg_type,
  output logic        out_last_of_message,
  output logic [2:0]  out_event_res
);
  import wsfd_pkg::*;

  // Largest length that fits in LENGTH_WIDTH bits
  localparam logic [AccWidth-1:0] LenLimit = (LENGTH_WIDTH >= AccWidth) ?
    {AccWidth{1'b1}} : ((64'd1 << LENGTH_WIDTH) - 64'd1);

  // State registers
  logic [31:0]             max_frame_r;
  phase_t                  phase_r, phase_nxt;
  logic [3:0]              hdr_cnt_r, hdr_cnt_nxt;
  logic [AccWidth-1:0]     len_acc_r, len_acc_nxt;
  logic [LENGTH_WIDTH-1:0] remain_r, remain_nxt;
  logic                    ext64_r, ext64_nxt;
  logic [31:0]             mask_key_r, mask_key_nxt;
  logic                    mask_on_r, mask_on_nxt;
  logic [1:0]              mask_pos_r, mask_pos_nxt;
  logic [3:0]              frame_op_r, frame_op_nxt;
  logic                    frame_fin_r, frame_fin_nxt;
  logic [3:0]              msg_op_r, msg_op_nxt;

  // Output register
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [3:0]  out_type_r;
  logic        out_last_r;
  event_t      out_ev_r;

  // Step results
  logic        emit;
  logic [7:0]  res_byte;
  logic [3:0]  res_type;
  logic        res_last;
  event_t      res_ev;

  logic                in_acc;
  logic [AccWidth-1:0] acc_shift;
  logic [AccWidth-1:0] len_in;
  logic [3:0]          hdr_inc;
  logic                ext_last;
  logic                bad_len;
  logic                over;
  logic                do_len;
  logic                do_end;
  logic [3:0]          data_type;
  logic [7:0]          key_byte;
  logic                end_emit;
  event_t              end_ev;
  logic                pay_last;

  // Handshakes: the output register frees the input side
  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;

  // Datapath helpers
  assign acc_shift = {len_acc_r[AccWidth-9:0], in_byte};
  assign hdr_inc   = 4'(hdr_cnt_r + 4'd1);
  assign ext_last  = (hdr_inc == (ext64_r ? ExtBytes64 : ExtBytes16));
  assign bad_len   = ext64_r ? ((acc_shift <= MaxShort) || acc_shift[AccWidth-1])
                             : (acc_shift < MinExt16);
  assign len_in    = (phase_r == PH_B1) ? AccWidth'(in_byte[6:0]) : acc_shift;
  assign over      = (len_in > AccWidth'(max_frame_r)) || (len_in > LenLimit);
  assign data_type = (frame_op_r == OP_CONT) ? msg_op_r : frame_op_r;
  assign pay_last  = (remain_r == LENGTH_WIDTH'(1));

  // Mask byte by position in the frame
  always_comb begin
    unique case (mask_pos_r)
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
  end

  // Control frame event at frame end
  always_comb begin
    end_emit = 1'b1;
    unique case (frame_op_r)
      OP_CLOSE: end_ev = EV_CLOSE;
      OP_PING:  end_ev = EV_PING;
      OP_PONG:  end_ev = EV_PONG;
      default: begin
        end_ev   = EV_DATA;
        end_emit = 1'b0;
      end
    endcase
  end

  // Parser next state and result
  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    len_acc_nxt  = len_acc_r;
    remain_nxt   = remain_r;
    ext64_nxt    = ext64_r;
    mask_key_nxt = mask_key_r;
    mask_on_nxt  = mask_on_r;
    mask_pos_nxt = mask_pos_r;
    frame_op_nxt = frame_op_r;
    frame_fin_nxt = frame_fin_r;
    msg_op_nxt   = msg_op_r;
    emit     = 1'b0;
    res_byte = 8'd0;
    res_type = frame_op_r;
    res_last = 1'b0;
    res_ev   = EV_DATA;
    do_len   = 1'b0;
    do_end   = 1'b0;

    unique case (phase_r)
      PH_B0: begin
        frame_fin_nxt = in_byte[7];
        frame_op_nxt  = in_byte[3:0];
        if (in_byte[3:0] == OP_TEXT || in_byte[3:0] == OP_BINARY) begin
          msg_op_nxt = in_byte[3:0];
        end
        phase_nxt = PH_B1;
      end
      PH_B1: begin
        mask_on_nxt = in_byte[7];
        len_acc_nxt = '0;
        hdr_cnt_nxt = '0;
        if (in_byte[6:0] == LEN7_EXT16) begin
          ext64_nxt = 1'b0;
          phase_nxt = PH_EXT;
        end else if (in_byte[6:0] == LEN7_EXT64) begin
          ext64_nxt = 1'b1;
          phase_nxt = PH_EXT;
        end else begin
          len_acc_nxt = len_in;
          do_len      = 1'b1;
        end
      end
      PH_EXT: begin
        len_acc_nxt = acc_shift;
        hdr_cnt_nxt = hdr_inc;
        if (ext_last) begin
          if (bad_len) begin
            phase_nxt = PH_HALT;
            emit      = 1'b1;
            res_ev    = EV_BADLEN;
          end else begin
            do_len = 1'b1;
          end
        end
      end
      PH_KEY: begin
        mask_key_nxt = {mask_key_r[23:0], in_byte};
        hdr_cnt_nxt  = hdr_inc;
        if (hdr_inc == KeyBytes) begin
          hdr_cnt_nxt  = '0;
          mask_pos_nxt = '0;
          if (remain_r == '0) begin
            do_end = 1'b1;
          end else begin
            phase_nxt = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        mask_pos_nxt = 2'(mask_pos_r + 2'd1);
        remain_nxt   = remain_r - LENGTH_WIDTH'(1);
        if (frame_op_r <= OP_BINARY &&
            (data_type == OP_TEXT || data_type == OP_BINARY)) begin
          emit     = 1'b1;
          res_byte = mask_on_r ? (in_byte ^ key_byte) : in_byte;
          res_type = data_type;
          res_last = pay_last && frame_fin_r;
        end
        do_end = pay_last;
      end
      PH_HALT: begin
        phase_nxt = PH_HALT;
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase

    // Length complete: limit check, then key, payload or frame end
    if (do_len) begin
      if (over) begin
        phase_nxt = PH_HALT;
        emit      = 1'b1;
        res_ev    = EV_OVER;
      end else begin
        remain_nxt   = len_in[LENGTH_WIDTH-1:0];
        mask_pos_nxt = '0;
        hdr_cnt_nxt  = '0;
        if (mask_on_nxt) begin
          phase_nxt = PH_KEY;
        end else if (len_in == '0) begin
          do_end = 1'b1;
        end else begin
          phase_nxt = PH_PAY;
        end
      end
    end

    // Frame end: message bookkeeping and control events
    if (do_end) begin
      phase_nxt = PH_B0;
      if (frame_op_r <= OP_BINARY && frame_fin_r) begin
        msg_op_nxt = OP_CONT;
      end
      if (end_emit) begin
        emit     = 1'b1;
        res_byte = 8'd0;
        res_type = frame_op_r;
        res_last = 1'b0;
        res_ev   = end_ev;
      end
    end
  end

  // Control and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r  <= MaxFrameReset;
      phase_r      <= PH_B0;
      hdr_cnt_r    <= '0;
      len_acc_r    <= '0;
      remain_r     <= '0;
      ext64_r      <= 1'b0;
      mask_key_r   <= '0;
      mask_on_r    <= 1'b0;
      mask_pos_r   <= '0;
      frame_op_r   <= OP_CONT;
      frame_fin_r  <= 1'b0;
      msg_op_r     <= OP_CONT;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_frame_r <= cfg_max_frame_bytes;
      end
      if (in_acc) begin
        phase_r     <= phase_nxt;
        hdr_cnt_r   <= hdr_cnt_nxt;
        len_acc_r   <= len_acc_nxt;
        remain_r    <= remain_nxt;
        ext64_r     <= ext64_nxt;
        mask_key_r  <= mask_key_nxt;
        mask_on_r   <= mask_on_nxt;
        mask_pos_r  <= mask_pos_nxt;
        frame_op_r  <= frame_op_nxt;
        frame_fin_r <= frame_fin_nxt;
        msg_op_r    <= msg_op_nxt;
      end
      if (in_acc && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each new result transfer
  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_byte_r <= res_byte;
      out_type_r <= res_type;
      out_last_r <= res_last;
      out_ev_r   <= res_ev;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_byte            = out_byte_r;
  assign out_msg_type        = out_type_r;
  assign out_last_of_message = out_last_r;
  assign out_event_res       = out_ev_r;

  // Checks
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit && (res_ev == EV_BADLEN || res_ev == EV_OVER))
      |=> (phase_r == PH_HALT))
    else $error("length error did not halt the parser");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit && res_last) |=> (phase_r == PH_B0))
    else $error("last byte of message did not end the frame");

  a_pay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAY) |-> (remain_r != '0))
    else $error("payload phase with no bytes left");

  a_key_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_KEY) |-> (hdr_cnt_r < KeyBytes))
    else $error("masking key byte count out of range");

  a_data_type: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_r == EV_DATA)
      |-> (out_type_r == OP_TEXT || out_type_r == OP_BINARY))
    else $error("data result without a text or binary type");

endmodule
